FILE: rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive steering package
// Shared constants, types and the CORDIC arctangent table for the heading
// steering unit.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Number of CORDIC rotations per heading vector (8 to 24).
  localparam int CORDIC_STEPS = 16;
  // The squared length is at most 2^31, so sixteen root digits cover it.
  localparam int SQRT_STEPS   = 16;
  localparam int LOOP_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int CNT_W        = $clog2(LOOP_STEPS);

  // The soft turn offset never exceeds the base speed, so a 16-bit quotient
  // is enough.
  localparam int DIV_STEPS    = 16;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  // Datapath widths.
  localparam int CFG_W  = 15;   // configuration registers
  localparam int IN_W   = 16;   // heading components
  localparam int CW     = 27;   // CORDIC x and y
  localparam int ZW     = 34;   // CORDIC angle accumulator, pi = 2^31
  localparam int AW     = 17;   // heading angle, pi = 32768
  localparam int MAG_W  = 16;   // absolute heading angle
  localparam int SPD_W  = 17;   // wheel speed
  localparam int SQ_W   = 31;   // square of one heading component
  localparam int RAD_W  = 32;   // sum of squares and root registers

  // Queue between front and back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_HARD_TURN = 2'd0,
    REG_SOFT_TURN = 2'd1,
    REG_STRAIGHT  = 2'd2,
    REG_MAX_SPEED = 2'd3
  } reg_index_e;

  // Turn mode codes.
  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_SOFT     = 2'd1,
    MODE_HARD     = 2'd2
  } turn_mode_e;

  // Item classes produced by the front end.
  typedef enum logic {
    ITEM_AXIS   = 1'b0,   // vector on an axis, angle is known exactly
    ITEM_CORDIC = 1'b1    // angle comes from the CORDIC iterations
  } item_class_e;

  typedef struct packed {
    logic [CFG_W-1:0] hard_turn_angle;
    logic [CFG_W-1:0] soft_turn_angle;
    logic [CFG_W-1:0] straight_angle;
    logic [CFG_W-1:0] speed_limit;
  } dds_cfg_t;

  localparam dds_cfg_t CFG_RESET = '{
    hard_turn_angle: 15'd16384,
    soft_turn_angle: 15'd8192,
    straight_angle:  15'd1820,
    speed_limit:     15'd2560
  };

  // One classified heading vector as it travels from front to back.
  typedef struct packed {
    item_class_e           cls;
    logic signed [AW-1:0]  axis_angle;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [ZW-1:0]  z0;
    logic [SQ_W-1:0]       sq_x;
    logic [SQ_W-1:0]       sq_y;
  } dds_item_t;

  // Exact angles for vectors on an axis.
  localparam logic signed [AW-1:0] ANGLE_ZERO = AW'(0);
  localparam logic signed [AW-1:0] ANGLE_HALF = AW'(16384);
  localparam logic signed [AW-1:0] ANGLE_PI   = AW'(32768);

  // Quarter turn in CORDIC angle units.
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);

  // Starting digit of the square root: the top power of four of the radicand.
  localparam logic [RAD_W-1:0] SQ_BIT_INIT = RAD_W'(1) << (2 * SQRT_STEPS - 2);

  // atan(2^-i) with pi = 2^31.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    begin
      case (idx)
        5'd0:    val = ZW'(536870912);
        5'd1:    val = ZW'(316933406);
        5'd2:    val = ZW'(167458907);
        5'd3:    val = ZW'(85004756);
        5'd4:    val = ZW'(42667331);
        5'd5:    val = ZW'(21354465);
        5'd6:    val = ZW'(10679838);
        5'd7:    val = ZW'(5340245);
        5'd8:    val = ZW'(2670163);
        5'd9:    val = ZW'(1335087);
        5'd10:   val = ZW'(667544);
        5'd11:   val = ZW'(333772);
        5'd12:   val = ZW'(166886);
        5'd13:   val = ZW'(83443);
        5'd14:   val = ZW'(41722);
        5'd15:   val = ZW'(20861);
        5'd16:   val = ZW'(10430);
        5'd17:   val = ZW'(5215);
        5'd18:   val = ZW'(2608);
        5'd19:   val = ZW'(1304);
        5'd20:   val = ZW'(652);
        5'd21:   val = ZW'(326);
        5'd22:   val = ZW'(163);
        5'd23:   val = ZW'(81);
        default: val = ZW'(0);
      endcase
      return val;
    end
  endfunction

endpackage

FILE: rtl/dds_front.sv
// ----------------------------------------------------------------------------
// Heading steering front end
// Accepts heading vectors, classifies axis cases, pre-rotates the left half
// plane for the CORDIC and squares the components for the length.
// ----------------------------------------------------------------------------
module dds_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     heading_x_i,
  input  logic signed [15:0]     heading_y_i,
  output logic                   push_o,
  input  logic                   full_i,
  output dds_pkg::dds_item_t     item_o
);
  import dds_pkg::*;

  logic                  valid_q, valid_d;
  logic signed [IN_W-1:0] x_q, x_d, y_q, y_d;
  logic                  accept;
  logic signed [CW-1:0]  xs, ys;
  logic signed [31:0]    sqx, sqy;

  // The stage holds one transaction until the queue has room for it.
  assign in_stall_o = valid_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~full_i;
  assign valid_d    = accept | (valid_q & full_i);
  assign x_d        = accept ? heading_x_i : x_q;
  assign y_d        = accept ? heading_y_i : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  // Scale to the CORDIC fixed point and square the components.
  assign xs  = CW'(x_q) <<< 8;
  assign ys  = CW'(y_q) <<< 8;
  assign sqx = 32'(x_q) * 32'(x_q);
  assign sqy = 32'(y_q) * 32'(y_q);

  // Classify the vector and rotate the left half plane into the right one.
  always_comb begin
    item_o            = '0;
    item_o.sq_x       = SQ_W'(sqx);
    item_o.sq_y       = SQ_W'(sqy);
    item_o.cls        = ITEM_CORDIC;
    item_o.axis_angle = ANGLE_ZERO;
    item_o.cx         = xs;
    item_o.cy         = ys;
    item_o.z0         = '0;
    if (y_q == 16'sd0) begin
      item_o.cls        = ITEM_AXIS;
      item_o.axis_angle = (x_q < 16'sd0) ? ANGLE_PI : ANGLE_ZERO;
    end else if (x_q == 16'sd0) begin
      item_o.cls        = ITEM_AXIS;
      item_o.axis_angle = (y_q > 16'sd0) ? ANGLE_HALF : -ANGLE_HALF;
    end else if (x_q < 16'sd0) begin
      if (y_q >= 16'sd0) begin
        item_o.cx = ys;
        item_o.cy = -xs;
        item_o.z0 = Z_QUARTER;
      end else begin
        item_o.cx = -ys;
        item_o.cy = xs;
        item_o.z0 = -Z_QUARTER;
      end
    end
  end

endmodule

FILE: rtl/dds_queue.sv
// ----------------------------------------------------------------------------
// Heading steering item queue
// Short first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module dds_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dds_pkg::dds_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output dds_pkg::dds_item_t item_o
);
  import dds_pkg::*;

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  dds_item_t         mem_q [QUEUE_DEPTH];

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointers wrap naturally because the depth is a power of two.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/dds_back.sv
// ----------------------------------------------------------------------------
// Heading steering back end
// Runs the CORDIC and the square root side by side, updates the turn mode,
// divides for the soft turn offset and holds the result register.
// ----------------------------------------------------------------------------
module dds_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dds_pkg::dds_cfg_t       cfg_i,
  input  logic                    empty_i,
  input  dds_pkg::dds_item_t      item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [16:0]      left_speed_o,
  output logic signed [16:0]      right_speed_o,
  output logic [1:0]              turn_mode_out_o
);
  import dds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_ANGLE,
    S_MODE,
    S_DIV_SET,
    S_DIV,
    S_OUT
  } state_e;

  // Control and result registers.
  state_e                 state_q, state_d;
  turn_mode_e             mode_q, mode_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [SPD_W-1:0] left_q, left_d, right_q, right_d;
  logic [1:0]             tmode_q, tmode_d;

  // Datapath registers.
  item_class_e            cls_q, cls_d;
  logic signed [AW-1:0]   axis_angle_q, axis_angle_d;
  logic signed [CW-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic [RAD_W-1:0]       sq_rem_q, sq_rem_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [AW-1:0]   angle_q, angle_d;
  logic [MAG_W-1:0]       mag_q, mag_d;
  logic [CFG_W-1:0]       base_q, base_d;
  logic [SQ_W-1:0]        prod_q, prod_d;
  logic [15:0]            div_rem_q, div_rem_d, div_low_q, div_low_d, div_quo_q, div_quo_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;

  // Combinational helpers.
  logic signed [CW-1:0]   xs, ys;
  logic [RAD_W-1:0]       sq_trial, div_num;
  logic signed [17:0]     r_wide;
  logic signed [AW-1:0]   angle_c;
  logic [15:0]            len;
  logic [16:0]            div_trial, div_den;
  logic signed [SPD_W-1:0] base_s, d_s, max_s, slow, fast;
  logic                   out_free;

  assign pop_o           = (state_q == S_IDLE) && !empty_i;
  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign turn_mode_out_o = tmode_q;
  assign out_free        = !out_valid_q || !out_stall_i;

  // Shared arithmetic terms.
  assign xs        = cx_q >>> cnt_q;
  assign ys        = cy_q >>> cnt_q;
  assign sq_trial  = sq_res_q + sq_bit_q;
  assign r_wide    = 18'((z_q + ZW'(32768)) >>> 16);
  assign len       = sq_res_q[15:0];
  assign div_num   = {prod_q, 1'b0} + RAD_W'(cfg_i.hard_turn_angle);
  assign div_den   = {1'b0, cfg_i.hard_turn_angle, 1'b0};
  assign div_trial = {div_rem_q, div_low_q[15]};
  assign base_s    = SPD_W'(base_q);
  assign d_s       = SPD_W'(div_quo_q);
  assign max_s     = SPD_W'(cfg_i.speed_limit);

  // The angle is kept inside (-pi, pi].
  always_comb begin
    if (cls_q == ITEM_AXIS) begin
      angle_c = axis_angle_q;
    end else if (r_wide > 18'sd32768) begin
      angle_c = ANGLE_PI;
    end else if (r_wide < -18'sd32767) begin
      angle_c = -AW'(32767);
    end else begin
      angle_c = AW'(r_wide);
    end
  end

  // Wheel speeds for the current mode, before the left and right swap.
  always_comb begin
    case (mode_q)
      MODE_SOFT: begin
        slow = base_s - d_s;
        fast = base_s + d_s;
      end
      MODE_HARD: begin
        slow = -max_s;
        fast = max_s;
      end
      default: begin
        slow = base_s;
        fast = base_s;
      end
    endcase
  end

  // Next state and datapath updates.
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    out_valid_d  = out_valid_q && out_stall_i;
    left_d       = left_q;
    right_d      = right_q;
    tmode_d      = tmode_q;
    cls_d        = cls_q;
    axis_angle_d = axis_angle_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    z_d          = z_q;
    sq_rem_d     = sq_rem_q;
    sq_res_d     = sq_res_q;
    sq_bit_d     = sq_bit_q;
    cnt_d        = cnt_q;
    angle_d      = angle_q;
    mag_d        = mag_q;
    base_d       = base_q;
    prod_d       = prod_q;
    div_rem_d    = div_rem_q;
    div_low_d    = div_low_q;
    div_quo_d    = div_quo_q;
    div_cnt_d    = div_cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          cls_d        = item_i.cls;
          axis_angle_d = item_i.axis_angle;
          cx_d         = item_i.cx;
          cy_d         = item_i.cy;
          z_d          = item_i.z0;
          sq_rem_d     = RAD_W'(item_i.sq_x) + RAD_W'(item_i.sq_y);
          sq_res_d     = '0;
          sq_bit_d     = SQ_BIT_INIT;
          cnt_d        = '0;
          state_d      = S_ITER;
        end
      end

      // One CORDIC rotation and one root digit per cycle.
      S_ITER: begin
        if ((32'(cnt_q) < CORDIC_STEPS) && (cls_q == ITEM_CORDIC)) begin
          if (cy_q > 0) begin
            cx_d = cx_q + ys;
            cy_d = cy_q - xs;
            z_d  = z_q + atan_entry(5'(cnt_q));
          end else begin
            cx_d = cx_q - ys;
            cy_d = cy_q + xs;
            z_d  = z_q - atan_entry(5'(cnt_q));
          end
        end
        if (32'(cnt_q) < SQRT_STEPS) begin
          if (sq_rem_q >= sq_trial) begin
            sq_rem_d = sq_rem_q - sq_trial;
            sq_res_d = (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_d = sq_res_q >> 1;
          end
          sq_bit_d = sq_bit_q >> 2;
        end
        if (cnt_q == CNT_W'(LOOP_STEPS - 1)) begin
          state_d = S_ANGLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Final angle, its magnitude and the capped base speed.
      S_ANGLE: begin
        angle_d = angle_c;
        mag_d   = MAG_W'((angle_c < 0) ? -angle_c : angle_c);
        base_d  = (len < {1'b0, cfg_i.speed_limit}) ? CFG_W'(len) : cfg_i.speed_limit;
        state_d = S_MODE;
      end

      // Hysteresis checks chained in order: hard, soft, then straight.
      S_MODE: begin
        mode_d = mode_q;
        if ((mode_d == MODE_HARD) && (mag_q <= {1'b0, cfg_i.soft_turn_angle})) begin
          mode_d = MODE_SOFT;
        end
        if (mode_d == MODE_SOFT) begin
          if (mag_q > {1'b0, cfg_i.hard_turn_angle}) begin
            mode_d = MODE_HARD;
          end else if (mag_q <= {1'b0, cfg_i.straight_angle}) begin
            mode_d = MODE_STRAIGHT;
          end
        end
        if (mode_d == MODE_STRAIGHT) begin
          if (mag_q > {1'b0, cfg_i.hard_turn_angle}) begin
            mode_d = MODE_HARD;
          end else if (mag_q > {1'b0, cfg_i.straight_angle}) begin
            mode_d = MODE_SOFT;
          end
        end
        prod_d    = SQ_W'(base_q) * SQ_W'(mag_q);
        div_quo_d = '0;
        if ((mode_d == MODE_SOFT) && (cfg_i.hard_turn_angle != '0)) begin
          state_d = S_DIV_SET;
        end else begin
          state_d = S_OUT;
        end
      end

      // Rounded numerator; its upper half is already below the divisor.
      S_DIV_SET: begin
        div_rem_d = div_num[31:16];
        div_low_d = div_num[15:0];
        div_cnt_d = '0;
        state_d   = S_DIV;
      end

      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        if (div_trial >= div_den) begin
          div_rem_d = 16'(div_trial - div_den);
          div_quo_d = {div_quo_q[14:0], 1'b1};
        end else begin
          div_rem_d = div_trial[15:0];
          div_quo_d = {div_quo_q[14:0], 1'b0};
        end
        div_low_d = {div_low_q[14:0], 1'b0};
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_OUT;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end

      // A positive angle turns left, so the left wheel is the slow one.
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          left_d      = (angle_q > 0) ? slow : fast;
          right_d     = (angle_q > 0) ? fast : slow;
          tmode_d     = 2'(mode_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, turn mode and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_STRAIGHT;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      tmode_q     <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      right_q     <= right_d;
      tmode_q     <= tmode_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cls_q        <= cls_d;
    axis_angle_q <= axis_angle_d;
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    z_q          <= z_d;
    sq_rem_q     <= sq_rem_d;
    sq_res_q     <= sq_res_d;
    sq_bit_q     <= sq_bit_d;
    cnt_q        <= cnt_d;
    angle_q      <= angle_d;
    mag_q        <= mag_d;
    base_q       <= base_d;
    prod_q       <= prod_d;
    div_rem_q    <= div_rem_d;
    div_low_q    <= div_low_d;
    div_quo_q    <= div_quo_d;
    div_cnt_q    <= div_cnt_d;
  end

endmodule

FILE: rtl/diff_drive_heading_steering_unit.sv
// ----------------------------------------------------------------------------
// Differential drive heading steering unit
// Turns a heading vector into left and right wheel speeds with a
// three-state turn mode that moves by hysteresis on the heading angle.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  heading_x_i, heading_y_i
//   out      output     out_valid_o/out_stall_i  left_speed_o, right_speed_o,
//                                                turn_mode_out_o
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// A transaction passes the front stage register and the queue; the back end then
// runs the shared CORDIC and square root loop, then the angle, mode and output states;
// a soft turn adds the bit-serial divider before the output state.
// Reset clears the turn mode to straight and loads the register defaults.
// A two-entry queue lets the front accept while the back is busy, and the
// back starts the next transaction while a finished result is stalled.
// ----------------------------------------------------------------------------
module diff_drive_heading_steering_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] heading_x_i,
  input  logic signed [15:0] heading_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] left_speed_o,
  output logic signed [16:0] right_speed_o,
  output logic [1:0]         turn_mode_out_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i
);
  import dds_pkg::*;

  dds_cfg_t  cfg_q, cfg_d;
  dds_item_t front_item, queue_item;
  logic      push, full, pop, empty;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_HARD_TURN: cfg_d.hard_turn_angle = cfg_data_i;
        REG_SOFT_TURN: cfg_d.soft_turn_angle = cfg_data_i;
        REG_STRAIGHT:  cfg_d.straight_angle  = cfg_data_i;
        REG_MAX_SPEED: cfg_d.speed_limit     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .heading_x_i (heading_x_i),
    .heading_y_i (heading_y_i),
    .push_o      (push),
    .full_i      (full),
    .item_o      (front_item)
  );

  dds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  dds_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .item_i          (queue_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .right_speed_o   (right_speed_o),
    .turn_mode_out_o (turn_mode_out_o)
  );

`ifndef SYNTHESIS
  // A hard turn spins in place with opposite wheel speeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (turn_mode_out_o == MODE_HARD)) |-> (left_speed_o == -right_speed_o))
    else $error("hard turn wheels are not opposite");

  // Straight driving runs both wheels at the same non-negative speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (turn_mode_out_o == MODE_STRAIGHT)) |->
      ((left_speed_o == right_speed_o) && !left_speed_o[16]))
    else $error("straight drive wheels differ or run backward");

  // A soft turn keeps the mean wheel speed at the base speed; the check is that the sum is non-negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (turn_mode_out_o == MODE_SOFT)) |->
      ((18'(left_speed_o) + 18'(right_speed_o)) >= 18'sd0))
    else $error("soft turn wheel sum is negative");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading steering unit testbench
// Drives heading vectors through the valid/stall input channel and checks
// every wheel command against a cycle-free predictor. The predictor covers the
// CORDIC angle, the integer length and the turn mode hysteresis. The run steps
// through several threshold and speed settings, with random idling on both
// channels, one long output hold and sender pauses between settings.
// ----------------------------------------------------------------------------
module tb;
  import dds_pkg::*;

  localparam int     HALF_PERIOD   = 6;
  localparam int     RESET_CYCLES  = 9;
  localparam int     SETTLE_CYCLES = 60;
  localparam int     LONG_HOLD     = 300;
  localparam int     PHASE_ITEMS   = 230;
  localparam longint CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } heading_t;

  typedef struct packed {
    logic [16:0] left;
    logic [16:0] right;
    turn_mode_e  mode;
  } wheel_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] heading_x_i;
  logic signed [15:0] heading_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [16:0] left_speed_o;
  logic signed [16:0] right_speed_o;
  logic [1:0]         turn_mode_out_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [14:0]        cfg_data_i;

  // Arctangent of 2^-i with pi = 2^31.
  longint atan_lut [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  // Predictor copy of the registers and the turn mode.
  logic [14:0] hard_thr;
  logic [14:0] soft_thr;
  logic [14:0] straight_thr;
  logic [14:0] speed_cap;
  turn_mode_e  mode_now;

  heading_t   heading_q[$];
  wheel_cmd_t wheel_cmd_q[$];

  bit     in_took;
  bit     out_took;
  bit     offering;
  bit     idle_on;
  bit     rx_hold_req;
  int     tx_gap;
  int     rx_wait;
  int     rx_hold;
  int     errors;
  int     items_sent;
  int     results_seen;
  int     settings_used;
  int     mode_hits [0:3];
  longint cycle_count;

  diff_drive_heading_steering_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .heading_x_i     (heading_x_i),
    .heading_y_i     (heading_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .right_speed_o   (right_speed_o),
    .turn_mode_out_o (turn_mode_out_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Signed heading angle by CORDIC vectoring, pi = 32768, range (-pi, pi].
  function automatic int heading_angle(longint hx, longint hy);
    longint cx, cy, zacc, sx, sy, tmp;
    int     n_rot;
    n_rot = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    zacc  = 0;
    if (hy == 0) return (hx < 0) ? 32768 : 0;
    if (hx == 0) return (hy > 0) ? 16384 : -16384;
    cx = hx * 256;
    cy = hy * 256;
    // Fold the left half plane into the right one by a quarter turn.
    if (cx < 0) begin
      tmp = cx;
      if (cy >= 0) begin
        cx   = cy;
        cy   = -tmp;
        zacc = 64'sd1073741824;
      end else begin
        cx   = -cy;
        cy   = tmp;
        zacc = -64'sd1073741824;
      end
    end
    for (int i = 0; i < n_rot; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy > 0) begin
        cx   = cx + sy;
        cy   = cy - sx;
        zacc = zacc + atan_lut[i];
      end else begin
        cx   = cx - sy;
        cy   = cy + sx;
        zacc = zacc - atan_lut[i];
      end
    end
    zacc = (zacc + 32768) >>> 16;
    if (zacc > 32768) zacc = 32768;
    if (zacc < -32767) zacc = -32767;
    return int'(zacc);
  endfunction

  // Floor of the square root, one digit per pass.
  function automatic longint floor_sqrt(longint v);
    longint root, digit;
    root  = 0;
    digit = 64'sd1 <<< 62;
    while (digit > v) digit = digit >> 2;
    while (digit != 0) begin
      if (v >= root + digit) begin
        v    = v - root - digit;
        root = (root >> 1) + digit;
      end else begin
        root = root >> 1;
      end
      digit = digit >> 2;
    end
    return root;
  endfunction

  // Wheel command for one heading; advances the predicted turn mode.
  function automatic wheel_cmd_t steer_predict(logic signed [15:0] px, logic signed [15:0] py);
    longint     hx, hy, len, base, cap, dlt, slow, fast;
    int         ang, mag, hard_i, soft_i, str_i;
    wheel_cmd_t res;
    hx     = px;
    hy     = py;
    hard_i = int'(hard_thr);
    soft_i = int'(soft_thr);
    str_i  = int'(straight_thr);
    cap    = longint'(speed_cap);
    ang    = heading_angle(hx, hy);
    mag    = (ang < 0) ? -ang : ang;
    len    = floor_sqrt(hx * hx + hy * hy);
    base   = (len < cap) ? len : cap;

    // Hysteresis checks run chained within one transaction.
    if (mode_now == MODE_HARD && mag <= soft_i) mode_now = MODE_SOFT;
    if (mode_now == MODE_SOFT) begin
      if (mag > hard_i) mode_now = MODE_HARD;
      else if (mag <= str_i) mode_now = MODE_STRAIGHT;
    end
    if (mode_now == MODE_STRAIGHT) begin
      if (mag > hard_i) mode_now = MODE_HARD;
      else if (mag > str_i) mode_now = MODE_SOFT;
    end

    case (mode_now)
      MODE_SOFT: begin
        dlt = 0;
        if (hard_i != 0) dlt = (base * mag * 2 + hard_i) / (longint'(hard_i) * 2);
        slow = base - dlt;
        fast = base + dlt;
      end
      MODE_HARD: begin
        slow = -cap;
        fast = cap;
      end
      default: begin
        slow = base;
        fast = base;
      end
    endcase

    // A positive angle turns left, so the left wheel is the slower one.
    if (ang > 0) begin
      res.left  = 17'(slow);
      res.right = 17'(fast);
    end else begin
      res.left  = 17'(fast);
      res.right = 17'(slow);
    end
    res.mode = mode_now;
    return res;
  endfunction

  // Mixed random headings: full range, near the speed cap, near the axes,
  // and sweeps across the turn thresholds.
  function automatic heading_t random_heading();
    heading_t h;
    int       kind, px, py;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:3]: begin
        px = int'($urandom_range(0, 65535)) - 32768;
        py = int'($urandom_range(0, 65535)) - 32768;
      end
      [4:6]: begin
        px = int'($urandom_range(0, 8000)) - 4000;
        py = int'($urandom_range(0, 8000)) - 4000;
      end
      7: begin
        px = int'($urandom_range(0, 65535)) - 32768;
        py = int'($urandom_range(0, 16)) - 8;
      end
      8: begin
        px = int'($urandom_range(0, 16)) - 8;
        py = int'($urandom_range(0, 65535)) - 32768;
      end
      default: begin
        px = ($urandom_range(0, 1) != 0) ? 1500 : -1500;
        py = int'($urandom_range(0, 6000)) - 3000;
      end
    endcase
    h.x = 16'(px);
    h.y = 16'(py);
    return h;
  endfunction

  // Input acceptance: predict the wheel command for each transaction taken.
  always @(posedge clk_i) begin
    wheel_cmd_t pred;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred        = steer_predict(heading_x_i, heading_y_i);
      wheel_cmd_q = {wheel_cmd_q, pred};
      items_sent++;
      in_took = 1'b1;
    end
  end

  // Output monitor: compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    wheel_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_took = 1'b1;
      if (wheel_cmd_q.size() == 0) begin
        $error("result with no prediction waiting: left %0d right %0d mode %0d",
               left_speed_o, right_speed_o, turn_mode_out_o);
        errors++;
      end else begin
        want = wheel_cmd_q.pop_front();
        results_seen++;
        mode_hits[want.mode]++;
        if (left_speed_o !== want.left) begin
          $error("left_speed: expected %0d, actual %0d", $signed(want.left), left_speed_o);
          errors++;
        end
        if (right_speed_o !== want.right) begin
          $error("right_speed: expected %0d, actual %0d", $signed(want.right), right_speed_o);
          errors++;
        end
        if (turn_mode_out_o !== want.mode) begin
          $error("turn_mode_out: expected %0d, actual %0d", want.mode, turn_mode_out_o);
          errors++;
        end
      end
    end
  end

  // Sender: present the next heading after a random gap.
  always @(negedge clk_i) begin
    heading_t nxt;
    if (in_took) begin
      in_took  = 1'b0;
      offering = 1'b0;
      tx_gap   = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (!offering && rst_ni) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (heading_q.size() != 0) begin
        nxt         = heading_q.pop_front();
        offering    = 1'b1;
        heading_x_i <= nxt.x;
        heading_y_i <= nxt.y;
      end
    end
    in_valid_i <= offering;
  end

  // Receiver: random stall per result, plus one long hold on request.
  always @(negedge clk_i) begin
    logic stl;
    stl = 1'b0;
    if (out_took) begin
      out_took = 1'b0;
      rx_wait  = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      stl = 1'b1;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold     = LONG_HOLD - 1;
      stl         = 1'b1;
    end else if (rx_wait > 0 && out_valid_o) begin
      rx_wait--;
      stl = 1'b1;
    end
    out_stall_i <= stl;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[diff_drive_heading_steering_unit] ERROR");
      $finish;
    end
  end

  // Wait until every queued heading is taken and every result has come back.
  task automatic wait_drained();
    while (heading_q.size() != 0 || offering || wheel_cmd_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_HARD_TURN: hard_thr     = val;
      REG_SOFT_TURN: soft_thr     = val;
      REG_STRAIGHT:  straight_thr = val;
      default:       speed_cap    = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reprogram all registers once the block has gone quiet.
  task automatic apply_setting(logic [14:0] hard, logic [14:0] relax,
                               logic [14:0] straight, logic [14:0] cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(REG_HARD_TURN, hard);
    write_reg(REG_SOFT_TURN, relax);
    write_reg(REG_STRAIGHT, straight);
    write_reg(REG_MAX_SPEED, cap);
    settings_used++;
  endtask

  task automatic queue_random(int count);
    heading_t h;
    for (int i = 0; i < count; i++) begin
      h         = random_heading();
      heading_q = {heading_q, h};
    end
  endtask

  task automatic queue_heading(int px, int py);
    heading_t h;
    h.x       = 16'(px);
    h.y       = 16'(py);
    heading_q = {heading_q, h};
  endtask

  initial begin
    int hv, sv, tv;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    heading_x_i  = '0;
    heading_y_i  = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_HARD_TURN;
    cfg_data_i   = '0;
    idle_on      = 1'b1;
    hard_thr     = CFG_RESET.hard_turn_angle;
    soft_thr     = CFG_RESET.soft_turn_angle;
    straight_thr = CFG_RESET.straight_angle;
    speed_cap    = CFG_RESET.speed_limit;
    mode_now     = MODE_STRAIGHT;
    settings_used = 1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed headings under the reset settings: zero vector, the axes,
    // component extremes, rounding toward minus pi and mode walks.
    queue_heading(0, 0);
    queue_heading(256, 0);
    queue_heading(-256, 0);
    queue_heading(0, 256);
    queue_heading(0, -256);
    queue_heading(32767, 0);
    queue_heading(-32768, 0);
    queue_heading(0, 32767);
    queue_heading(0, -32768);
    queue_heading(32767, 32767);
    queue_heading(-32768, -32768);
    queue_heading(-32768, -1);
    queue_heading(0, 0);
    queue_heading(1000, 100);
    queue_heading(1000, 600);
    queue_heading(-1000, 600);
    queue_heading(1000, 1000);
    queue_heading(1000, -3000);
    queue_heading(-1, 1);
    queue_heading(1, -1);
    queue_heading(-1000, -1);
    queue_heading(1, 1);
    queue_heading(-32768, 32767);
    queue_heading(32767, -32768);
    queue_heading(-20000, -1);

    // Reset values written back explicitly.
    apply_setting(15'd16384, 15'd8192, 15'd1820, 15'd2560);
    queue_random(PHASE_ITEMS);

    // Top of every register range, without idling.
    apply_setting(15'd32767, 15'd32767, 15'd32767, 15'd32767);
    idle_on = 1'b0;
    queue_random(PHASE_ITEMS);

    // Bottom of the ranges: no speed at all.
    apply_setting(15'd1, 15'd0, 15'd0, 15'd0);
    idle_on = 1'b1;
    queue_random(PHASE_ITEMS);

    // Random ordered thresholds; the sender pauses halfway until drained.
    hv = $urandom_range(1, 32767);
    sv = $urandom_range(0, hv);
    tv = $urandom_range(0, sv);
    apply_setting(15'(hv), 15'(sv), 15'(tv), 15'($urandom_range(0, 32767)));
    queue_random(PHASE_ITEMS / 2);
    wait_drained();
    queue_random(PHASE_ITEMS / 2);

    // Any 15-bit values, ordering not enforced.
    apply_setting(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
    queue_random(PHASE_ITEMS);

    // Zero hard threshold: any nonzero angle spins in place.
    apply_setting(15'd0, 15'd0, 15'd0, 15'd32767);
    queue_random(PHASE_ITEMS);

    // Narrow bands with a long output hold so the input backs up.
    apply_setting(15'd4000, 15'd3000, 15'd500, 15'd32767);
    queue_random(PHASE_ITEMS);
    rx_hold_req = 1'b1;

    // Moderate settings, no idling on either side.
    apply_setting(15'd12000, 15'd6000, 15'd3000, 15'd1000);
    idle_on = 1'b0;
    queue_random(PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Sent %0d headings over %0d register settings, checked %0d wheel commands",
             items_sent, settings_used, results_seen);
    $display("Turn modes seen: straight %0d, soft %0d, hard %0d; %0d mismatches",
             mode_hits[MODE_STRAIGHT], mode_hits[MODE_SOFT], mode_hits[MODE_HARD], errors);
    if (errors == 0 && wheel_cmd_q.size() == 0) begin
      $display("[diff_drive_heading_steering_unit] OK");
    end else begin
      $display("[diff_drive_heading_steering_unit] ERROR");
    end
    $finish;
  end

endmodule
